FILE: rtl/ccmi_pkg.sv
`default_nettype none

package ccmi_pkg;

   // Default widths of the counts and of the fixed-point fraction.
   localparam int COUNT_BITS_DEFAULT    = 20;
   localparam int FRACTION_BITS_DEFAULT = 30;

   // Fixed widths of the result, the running sums and the reciprocal of the total.
   localparam int RESULT_BITS = 32;
   localparam int SUM_BITS    = 40;
   localparam int RECIP_BITS  = 32;

   // Configuration port geometry.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Natural logarithm of two with 30 fraction bits, rounded to nearest.
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   // Register indexes, taken from paddr[2].
   typedef enum logic [0:0] {
      CASE_TOTAL_REG    = 1'b0,
      CONTROL_TOTAL_REG = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

FILE: rtl/ccmi_req_if.sv
`default_nettype none

interface ccmi_req_if #(
   parameter int COUNT_BITS = ccmi_pkg::COUNT_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] case_count;
   logic [COUNT_BITS-1:0] control_count;
   logic                  last_cell;

   modport source (output valid, output case_count, output control_count,
                   output last_cell, input ready);
   modport sink   (input valid, input case_count, input control_count,
                   input last_cell, output ready);
endinterface

`default_nettype wire

FILE: rtl/ccmi_rsp_if.sv
`default_nettype none

interface ccmi_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [ccmi_pkg::RESULT_BITS-1:0] mutual_information;

   modport source (output valid, output mutual_information, input ready);
   modport sink   (input valid, input mutual_information, output ready);
endinterface

`default_nettype wire

FILE: rtl/ccmi_mul.sv
`default_nettype none

// Shared multiplier with a registered product.
module ccmi_mul #(
   parameter int A_BITS = 32,
   parameter int B_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic [A_BITS-1:0]        op_a,
   input  wire logic [B_BITS-1:0]        op_b,
   output logic      [A_BITS+B_BITS-1:0] prod_ff
);

   logic [A_BITS+B_BITS-1:0] prod_in;

   assign prod_in = (A_BITS + B_BITS)'(op_a) * (A_BITS + B_BITS)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

FILE: rtl/ccmi_csr.sv
`default_nettype none

// Configuration registers behind an APB-style port.
module ccmi_csr #(
   parameter int COUNT_BITS = ccmi_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [ccmi_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [ccmi_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [ccmi_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                    pready,
   output logic      [COUNT_BITS-1:0]              case_total,
   output logic      [COUNT_BITS-1:0]              control_total,
   output logic                                    cfg_write
);

   logic [COUNT_BITS-1:0]   case_total_ff, case_total_in;
   logic [COUNT_BITS-1:0]   control_total_ff, control_total_in;
   ccmi_pkg::csr_index_type index;

   assign index     = ccmi_pkg::csr_index_type'(paddr[2]);
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      case_total_in    = case_total_ff;
      control_total_in = control_total_ff;
      if (cfg_write) begin
         unique case (index)
            ccmi_pkg::CASE_TOTAL_REG:    case_total_in    = pwdata[COUNT_BITS-1:0];
            ccmi_pkg::CONTROL_TOTAL_REG: control_total_in = pwdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ccmi_pkg::CASE_TOTAL_REG:
            prdata = ccmi_pkg::CSR_DATA_BITS'(case_total_ff);
         ccmi_pkg::CONTROL_TOTAL_REG:
            prdata = ccmi_pkg::CSR_DATA_BITS'(control_total_ff);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         case_total_ff    <= COUNT_BITS'(1);
         control_total_ff <= COUNT_BITS'(1);
      end else begin
         case_total_ff    <= case_total_in;
         control_total_ff <= control_total_in;
      end
   end

   assign case_total    = case_total_ff;
   assign control_total = control_total_ff;

endmodule

`default_nettype wire

FILE: rtl/ccmi_engine.sv
`default_nettype none

// Sequencer and datapath around the shared multiplier.
module ccmi_engine #(
   parameter int COUNT_BITS    = ccmi_pkg::COUNT_BITS_DEFAULT,
   parameter int FRACTION_BITS = ccmi_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [COUNT_BITS-1:0] case_total,
   input  wire logic [COUNT_BITS-1:0] control_total,
   input  wire logic                  cfg_write,
   ccmi_req_if.sink                   req,
   ccmi_rsp_if.source                 rsp
);

   localparam int CB   = COUNT_BITS;
   localparam int FB   = FRACTION_BITS;
   localparam int TB   = CB + 1;
   localparam int EB   = $clog2(TB + 1);
   localparam int PB   = FB + 1;
   localparam int KB   = $clog2(FB + 1);
   localparam int LB   = FB + 5;
   localparam int RB   = ccmi_pkg::RECIP_BITS;
   localparam int AW   = (CB > PB) ? CB : PB;
   localparam int PW   = AW + RB;
   localparam int SW   = 2 * FB + 2;
   localparam int TW   = FB + 2;
   localparam int QB   = $clog2(FB);
   localparam int DB   = $clog2(RB);
   localparam int NB   = ccmi_pkg::SUM_BITS;
   localparam int OB   = ccmi_pkg::RESULT_BITS;
   localparam int XB   = NB + 2;
   localparam logic [PB-1:0]   ONE    = PB'(1) << FB;
   localparam logic [2*FB:0]   HALF_W = (2 * FB + 1)'(1) << (FB - 1);
   localparam logic [SW:0]     HALF_S = (SW + 1)'(1) << (FB - 1);
   localparam logic [FB-1:0]   LN2F   = FB'((64'(ccmi_pkg::LN2_Q30)
                                        + ((64'd1 << (30 - FB)) >> 1)) >> (30 - FB));

   typedef enum logic [19:0] {
      S_IDLE   = 20'h00001,
      S_DSTART = 20'h00002,
      S_LEN    = 20'h00004,
      S_DIV    = 20'h00008,
      S_MULA   = 20'h00010,
      S_PROBA  = 20'h00020,
      S_MULB   = 20'h00040,
      S_PROBB  = 20'h00080,
      S_TERM   = 20'h00100,
      S_NORM   = 20'h00200,
      S_SQMUL  = 20'h00400,
      S_SQUPD  = 20'h00800,
      S_LMB    = 20'h01000,
      S_LMA    = 20'h02000,
      S_LADD   = 20'h04000,
      S_PMH    = 20'h08000,
      S_PML    = 20'h10000,
      S_PADD   = 20'h20000,
      S_ACC    = 20'h40000,
      S_OUT    = 20'h80000
   } state_type;

   state_type              state_ff, state_in;
   logic                   derive_ff, derive_in;
   logic [CB-1:0]          cc_ff, cc_in, nc_ff, nc_in;
   logic                   last_ff, last_in;
   logic [TB-1:0]          len_ff, len_in;
   logic [EB-1:0]          e_ff, e_in;
   logic [TB-1:0]          rem_ff, rem_in;
   logic [DB-1:0]          dcnt_ff, dcnt_in;
   logic [RB-1:0]          recip_ff, recip_in;
   logic [PB-1:0]          pc_ff, pc_in, pn_ff, pn_in, ps_ff, ps_in, p_ff, p_in;
   logic [1:0]             term_ff, term_in;
   logic [PB-1:0]          m_ff, m_in;
   logic [KB-1:0]          k_ff, k_in;
   logic [FB-1:0]          frac_ff, frac_in;
   logic [QB-1:0]          sqcnt_ff, sqcnt_in;
   logic [FB-1:0]          lacc_ff, lacc_in;
   logic [LB-1:0]          l_ff, l_in;
   logic [SW-1:0]          acc_ff, acc_in;
   logic signed [TW-1:0]   t_ff, t_in;
   logic signed [NB-1:0]   joint_ff, joint_in, marg_ff, marg_in;
   logic signed [OB-1:0]   label_ff, label_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [OB-1:0]   rsp_data_ff, rsp_data_in;

   logic [AW-1:0]          op_a;
   logic [RB-1:0]          op_b;
   logic [PW-1:0]          prod_ff;

   logic [TB-1:0]          tot;
   logic [CB-1:0]          c_a, c_b, c_sel;
   logic [6:0]             shamt;
   logic [PW-1:0]          pshift;
   logic [PB-1:0]          prob;
   logic [PB:0]            psum_p;
   logic [PB-1:0]          p_sel;
   logic [TB:0]            r2;
   logic                   ge;
   logic [FB+1:0]          sq;
   logic [KB-1:0]          a_val;
   logic [FB-1:0]          b_val;
   logic [2*FB:0]          lround;
   logic [SW:0]            tsum;
   logic signed [NB-1:0]   t_sum;
   logic signed [XB-1:0]   diff;

   function automatic logic signed [NB-1:0] sat_sum(input logic signed [NB:0] v);
      if (v[NB] != v[NB-1]) begin
         sat_sum = v[NB] ? {1'b1, {(NB - 1){1'b0}}} : {1'b0, {(NB - 1){1'b1}}};
      end else begin
         sat_sum = v[NB-1:0];
      end
   endfunction

   function automatic logic signed [OB-1:0] sat_out(input logic signed [XB-1:0] v);
      if (v > $signed(XB'({1'b0, {(OB - 1){1'b1}}}))) begin
         sat_out = {1'b0, {(OB - 1){1'b1}}};
      end else if (v < -$signed(XB'({1'b1, {(OB - 1){1'b0}}}))) begin
         sat_out = {1'b1, {(OB - 1){1'b0}}};
      end else begin
         sat_out = v[OB-1:0];
      end
   endfunction

   ccmi_mul #(.A_BITS(AW), .B_BITS(RB)) u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   // Shared datapath terms.
   assign tot    = {1'b0, case_total} + {1'b0, control_total};
   assign c_a    = derive_ff ? case_total : cc_ff;
   assign c_b    = derive_ff ? control_total : nc_ff;
   assign c_sel  = state_ff == S_PROBA ? c_a : c_b;
   assign shamt  = 7'(31 - FB) + 7'(e_ff);
   assign pshift = prod_ff >> shamt;
   assign prob   = (tot == '0) ? '0 :
                   ({1'b0, c_sel} >= tot) ? ONE : pshift[PB-1:0];
   assign psum_p = {1'b0, pc_ff} + {1'b0, prob};
   assign p_sel  = (term_ff == 2'd0) ? pc_ff : (term_ff == 2'd1) ? pn_ff : ps_ff;
   assign r2     = {rem_ff, 1'b1};
   assign ge     = r2 >= {1'b0, tot};
   assign sq     = prod_ff[2*FB+1:FB];
   assign a_val  = k_ff - KB'(frac_ff != '0);
   assign b_val  = -frac_ff;
   assign lround = {1'b0, prod_ff[2*FB-1:0]} + HALF_W;
   assign tsum   = {1'b0, acc_ff} + {1'b0, prod_ff[SW-1:0]} + HALF_S;
   assign t_sum  = {{(NB - TW){t_ff[TW-1]}}, t_ff};
   assign diff   = {{2{joint_ff[NB-1]}}, joint_ff}
                 - {{(XB - OB){label_ff[OB-1]}}, label_ff}
                 - {{2{marg_ff[NB-1]}}, marg_ff};

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         S_MULA:  begin op_a = AW'(c_a);   op_b = recip_ff;        end
         S_MULB:  begin op_a = AW'(c_b);   op_b = recip_ff;        end
         S_SQMUL: begin op_a = AW'(m_ff);  op_b = RB'(m_ff);       end
         S_LMB:   begin op_a = AW'(b_val); op_b = RB'(LN2F);       end
         S_LMA:   begin op_a = AW'(a_val); op_b = RB'(LN2F);       end
         S_PMH:   begin op_a = AW'(p_ff);  op_b = RB'(l_ff[LB-1:FB]); end
         S_PML:   begin op_a = AW'(p_ff);  op_b = RB'(l_ff[FB-1:0]);  end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      derive_in    = derive_ff;
      cc_in        = cc_ff;
      nc_in        = nc_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      e_in         = e_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      recip_in     = recip_ff;
      pc_in        = pc_ff;
      pn_in        = pn_ff;
      ps_in        = ps_ff;
      p_in         = p_ff;
      term_in      = term_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      frac_in      = frac_ff;
      sqcnt_in     = sqcnt_ff;
      lacc_in      = lacc_ff;
      l_in         = l_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      joint_in     = joint_ff;
      marg_in      = marg_ff;
      label_in     = label_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cc_in     = req.case_count;
               nc_in     = req.control_count;
               last_in   = req.last_cell;
               derive_in = 1'b0;
               state_in  = S_MULA;
            end
         end
         S_DSTART: begin
            if (tot == '0) begin
               recip_in = '0;
               label_in = '0;
               state_in = S_IDLE;
            end else begin
               len_in   = tot;
               e_in     = '0;
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (len_ff == '0) begin
               rem_in   = TB'({TB{1'b1}} >> (TB + 1 - int'(e_ff)));
               dcnt_in  = '0;
               state_in = S_DIV;
            end else begin
               len_in = len_ff >> 1;
               e_in   = e_ff + EB'(1);
            end
         end
         S_DIV: begin
            rem_in   = ge ? TB'(r2 - {1'b0, tot}) : r2[TB-1:0];
            recip_in = {recip_ff[RB-2:0], ge};
            dcnt_in  = dcnt_ff + DB'(1);
            if (dcnt_ff == DB'(RB - 1)) begin
               state_in = S_MULA;
            end
         end
         S_MULA: state_in = S_PROBA;
         S_PROBA: begin
            pc_in    = prob;
            state_in = S_MULB;
         end
         S_MULB: state_in = S_PROBB;
         S_PROBB: begin
            pn_in    = prob;
            ps_in    = (psum_p > {1'b0, ONE}) ? ONE : psum_p[PB-1:0];
            term_in  = 2'd0;
            state_in = S_TERM;
         end
         S_TERM: begin
            if (p_sel == '0) begin
               t_in     = '0;
               state_in = S_ACC;
            end else begin
               p_in     = p_sel;
               m_in     = p_sel;
               k_in     = '0;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (m_ff[FB]) begin
               sqcnt_in = '0;
               frac_in  = '0;
               state_in = S_SQMUL;
            end else begin
               m_in = m_ff << 1;
               k_in = k_ff + KB'(1);
            end
         end
         S_SQMUL: state_in = S_SQUPD;
         S_SQUPD: begin
            frac_in = {frac_ff[FB-2:0], sq[FB+1]};
            m_in    = sq[FB+1] ? sq[FB+1:1] : sq[FB:0];
            if (sqcnt_ff == QB'(FB - 1)) begin
               state_in = S_LMB;
            end else begin
               sqcnt_in = sqcnt_ff + QB'(1);
               state_in = S_SQMUL;
            end
         end
         S_LMB: state_in = S_LMA;
         S_LMA: begin
            lacc_in  = lround[2*FB-1:FB];
            state_in = S_LADD;
         end
         S_LADD: begin
            l_in     = LB'(lacc_ff) + prod_ff[LB-1:0];
            state_in = S_PMH;
         end
         S_PMH: state_in = S_PML;
         S_PML: begin
            acc_in   = {prod_ff[FB+1:0], {FB{1'b0}}};
            state_in = S_PADD;
         end
         S_PADD: begin
            t_in     = -$signed({1'b0, tsum[2*FB:FB]});
            state_in = S_ACC;
         end
         S_ACC: begin
            term_in  = term_ff + 2'd1;
            state_in = S_TERM;
            if (derive_ff) begin
               label_in = ((term_ff == 2'd0) ? '0 : label_ff)
                        + {{(OB - TW){t_ff[TW-1]}}, t_ff};
               if (term_ff == 2'd1) begin
                  state_in = S_IDLE;
               end
            end else if (term_ff == 2'd2) begin
               marg_in  = sat_sum({marg_ff[NB-1], marg_ff} + {t_sum[NB-1], t_sum});
               state_in = last_ff ? S_OUT : S_IDLE;
            end else begin
               joint_in = sat_sum({joint_ff[NB-1], joint_ff} + {t_sum[NB-1], t_sum});
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_data_in  = sat_out(diff);
               rsp_valid_in = 1'b1;
               joint_in     = '0;
               marg_in      = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // A register write restarts the derivation from the new totals.
      if (cfg_write) begin
         state_in  = S_DSTART;
         derive_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_DSTART;
         derive_ff    <= 1'b1;
         joint_ff     <= '0;
         marg_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         derive_ff    <= derive_in;
         joint_ff     <= joint_in;
         marg_ff      <= marg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cc_ff       <= cc_in;
      nc_ff       <= nc_in;
      last_ff     <= last_in;
      len_ff      <= len_in;
      e_ff        <= e_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      recip_ff    <= recip_in;
      pc_ff       <= pc_in;
      pn_ff       <= pn_in;
      ps_ff       <= ps_in;
      p_ff        <= p_in;
      term_ff     <= term_in;
      m_ff        <= m_in;
      k_ff        <= k_in;
      frac_ff     <= frac_in;
      sqcnt_ff    <= sqcnt_in;
      lacc_ff     <= lacc_in;
      l_ff        <= l_in;
      acc_ff      <= acc_in;
      t_ff        <= t_in;
      label_ff    <= label_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req.ready              = state_ff == S_IDLE;
   assign rsp.valid              = rsp_valid_ff;
   assign rsp.mutual_information = rsp_data_ff;

   // An accepted request always starts with the first probability multiply.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && !cfg_write |=> state_ff == S_MULA)
      else $error("accepted request did not start the sequence");

   // The reciprocal of the total is either zero or normalised to its top bit.
   a_recip_norm: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> recip_ff[RB-1] || recip_ff == '0)
      else $error("reciprocal of the total is not normalised");

   // Squaring only ever runs on a mantissa in [1, 2).
   a_mant_norm: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SQMUL |-> m_ff[FB])
      else $error("mantissa not normalised before squaring");

   // No probability exceeds one.
   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TERM |-> p_sel <= ONE)
      else $error("probability above one");

   // The label term is a sum of p*ln(p) terms and cannot be positive.
   a_label_sign: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> label_ff[OB-1] || label_ff == '0)
      else $error("label term out of range");

endmodule

`default_nettype wire

FILE: rtl/case_control_mutual_information_core.sv
`default_nettype none

// Case/control mutual information core. Each request carries one cell of a genotype
// contingency table (a case count, a control count and a last-cell flag); the core
// turns both counts and their sum into probabilities against the study total, adds
// p*ln(p) of the two counts into a joint sum and that of their sum into a marginal
// sum, and on the last cell returns joint minus label term minus marginal, in nats,
// as a signed fixed-point value with FRACTION_BITS fraction bits, saturated to 32
// bits. All arithmetic runs on one shared multiplier under a sequencer, so the core
// handles one request at a time and holds ready low while it works. The last cell of
// a table adds an output step. Each of the three probabilities is skipped when it is
// zero; otherwise it is normalised by one shift per leading zero below one, and the
// repeated squaring of the mantissa, one squaring per fraction bit, dominates. A
// finished result waits in an output register, and the core takes the next request
// meanwhile; if the previous result has not yet been taken when a table ends, the
// last cell waits for it. After reset and after every register write the core derives
// the reciprocal of the total (a restoring division of one bit per cycle) and then
// the label term from two logarithms; it accepts no request during that time.
// Registers: case_total at byte address 0, control_total at byte address 4, both
// reset to one.
module case_control_mutual_information_core #(
   parameter int COUNT_BITS    = ccmi_pkg::COUNT_BITS_DEFAULT,
   parameter int FRACTION_BITS = ccmi_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ccmi_req_if.sink                                req,
   ccmi_rsp_if.source                              rsp,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [ccmi_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [ccmi_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [ccmi_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                    pready
);

   logic [COUNT_BITS-1:0] case_total;
   logic [COUNT_BITS-1:0] control_total;
   logic                  cfg_write;

   // Register file; a write strobe also restarts the derivation in the engine.
   ccmi_csr #(.COUNT_BITS(COUNT_BITS)) u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .case_total    (case_total),
      .control_total (control_total),
      .cfg_write     (cfg_write)
   );

   // Sequencer, sums and the shared multiplier.
   ccmi_engine #(
      .COUNT_BITS    (COUNT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .case_total    (case_total),
      .control_total (control_total),
      .cfg_write     (cfg_write),
      .req           (req),
      .rsp           (rsp)
   );

endmodule

`default_nettype wire
